FILE: src/pnd_pkg.sv
// shared types, constants and helpers for the peak normalized three phase duty block
package pnd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int BOUND_W    = 16;
	localparam int DUTY_W     = 11;
	localparam int PWM_PERIOD = 1024;
	localparam int HALF       = PWM_PERIOD / 2;
	// quotient |p|*HALF/bound never exceeds HALF because bound >= |p|
	localparam int QUOT_W     = $clog2(HALF) + 1;
	localparam int REM_W      = BOUND_W + 1;
	localparam int MAG_W      = SAMPLE_W + 1;
	localparam int CNT_W      = $clog2(QUOT_W);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] phase_a;
		logic signed [SAMPLE_W-1:0] phase_b;
		logic signed [SAMPLE_W-1:0] phase_c;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty_a;
		logic [DUTY_W-1:0]  duty_b;
		logic [DUTY_W-1:0]  duty_c;
		logic [BOUND_W-1:0] bound_used;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic step;
	} lane_ctrl_t;

	function automatic logic [MAG_W-1:0] mag_of(logic signed [SAMPLE_W-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[SAMPLE_W-1], v};
		return v[SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
	endfunction

endpackage

FILE: src/peak_normalized_three_phase_duty.sv
// top level: running peak bound, lane sequencer and merged output register
// each item passes the states idle, bound, calc and done in that order
// a new item is taken only once the previous one has left done, calc runs the 10-step radix-2 divider in each lane
// the input side takes a new item while a finished result still waits in the output register
// reset (arst_n low, asynchronous) clears the peak, the initial bound, the sequencer and out_valid
// no clearing pass after reset, items are accepted on the first cycle out of reset
module peak_normalized_three_phase_duty import pnd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [BOUND_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_BOUND = 4'b0010,
		S_CALC  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   step_cnt_q;
	in_item_t           item_q;
	logic [BOUND_W-1:0] peak_q;
	logic [BOUND_W-1:0] init_bound_q;
	logic [BOUND_W-1:0] bound_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               in_acc;
	logic               out_free;
	lane_ctrl_t         lane_ctrl;
	logic [DUTY_W-1:0]  duty_a;
	logic [DUTY_W-1:0]  duty_b;
	logic [DUTY_W-1:0]  duty_c;
	logic [BOUND_W-1:0] base_bound;
	logic [MAG_W-1:0]   cand0;
	logic [MAG_W-1:0]   cand1;
	logic [MAG_W-1:0]   cand2;
	logic [MAG_W-1:0]   cand3;
	logic [MAG_W-1:0]   mag_a;
	logic [MAG_W-1:0]   mag_b;
	logic [MAG_W-1:0]   mag_c;

	// one item in flight, taken only when the sequencer is free
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// bound: largest of the stored peak, the initial bound and the three magnitudes
	assign mag_a      = mag_of(item_q.phase_a);
	assign mag_b      = mag_of(item_q.phase_b);
	assign mag_c      = mag_of(item_q.phase_c);
	assign base_bound = (init_bound_q > peak_q) ? init_bound_q : peak_q;
	assign cand0      = {1'b0, base_bound};
	assign cand1      = (mag_a > cand0) ? mag_a : cand0;
	assign cand2      = (mag_b > cand1) ? mag_b : cand1;
	assign cand3      = (mag_c > cand2) ? mag_c : cand2;

	// lanes load their magnitude while the bound is found, then step together
	assign lane_ctrl.start = (state_q == S_BOUND);
	assign lane_ctrl.step  = (state_q == S_CALC);

	pnd_lane u_lane_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.phase  (item_q.phase_a),
		.bound  (bound_q),
		.duty   (duty_a)
	);

	pnd_lane u_lane_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.phase  (item_q.phase_b),
		.bound  (bound_q),
		.duty   (duty_b)
	);

	pnd_lane u_lane_c (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.phase  (item_q.phase_c),
		.bound  (bound_q),
		.duty   (duty_c)
	);

	// sequencer, peak state, config register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_cnt_q   <= '0;
			peak_q       <= '0;
			init_bound_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_bound_q <= cfg_wdata;
			end
			// output register fills from the merge stage or empties on accept
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_BOUND;
					end
				end
				S_BOUND: begin
					// peak only grows, this item's bound becomes the new peak
					peak_q     <= cand3[BOUND_W-1:0];
					step_cnt_q <= '0;
					state_q    <= S_CALC;
				end
				S_CALC: begin
					step_cnt_q <= step_cnt_q + CNT_W'(1);
					if (step_cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// merge stage waits here until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == S_BOUND) begin
			bound_q <= cand3[BOUND_W-1:0];
		end
		if ((state_q == S_DONE) && out_free) begin
			out_q.duty_a     <= duty_a;
			out_q.duty_b     <= duty_b;
			out_q.duty_c     <= duty_c;
			out_q.bound_used <= bound_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: src/pnd_lane.sv
// one phase lane: restoring divider of |phase|*half by the bound, floor and offset
module pnd_lane import pnd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctrl_t                 ctrl,
	input  logic signed [SAMPLE_W-1:0] phase,
	input  logic [BOUND_W-1:0]         bound,
	output logic [DUTY_W-1:0]          duty
);

	localparam int SUM_W = DUTY_W + 2;

	logic [REM_W-1:0]  rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic              neg_q;
	logic [MAG_W-1:0]  mag;
	logic [REM_W-1:0]  dvsr;
	logic [REM_W-1:0]  diff;
	logic [REM_W-1:0]  rem_nx;
	logic              ge;
	logic              rem_nz;
	logic [SUM_W-1:0]  val;

	assign mag    = mag_of(phase);
	assign dvsr   = {1'b0, bound};
	assign ge     = rem_q >= dvsr;
	assign diff   = rem_q - dvsr;
	assign rem_nx = ge ? diff : rem_q;

	// datapath only, the sequencer in the top level qualifies it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quot_q <= '0;
			neg_q  <= 1'b0;
		end else if (ctrl.start) begin
			rem_q  <= REM_W'(mag);
			quot_q <= '0;
			neg_q  <= phase[SAMPLE_W-1];
		end else if (ctrl.step) begin
			rem_q  <= {rem_nx[REM_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	// nonzero remainder on a negative phase rounds one further down
	assign rem_nz = |rem_q;
	assign val = neg_q ? (SUM_W'(HALF) - SUM_W'(quot_q) - SUM_W'(rem_nz))
	                   : (SUM_W'(HALF) + SUM_W'(quot_q));

	always_comb begin
		if (bound == '0) begin
			duty = DUTY_W'(HALF);
		end else if (val[SUM_W-1]) begin
			duty = '0;
		end else if (val > SUM_W'(PWM_PERIOD)) begin
			duty = DUTY_W'(PWM_PERIOD);
		end else begin
			duty = val[DUTY_W-1:0];
		end
	end

endmodule

FILE: src/pnd_checker.sv
// port level checks for the peak normalized three phase duty block, with bind
module pnd_checker import pnd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input out_item_t          out_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// one item at a time: the input side closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in flight");

	// a zero bound gives the midpoint on every phase
	a_zero_bound_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.bound_used == '0) |->
		(out_data.duty_a == DUTY_W'(HALF)) && (out_data.duty_b == DUTY_W'(HALF)) &&
		(out_data.duty_c == DUTY_W'(HALF)))
		else $error("zero bound without midpoint duty");

	// no duty beyond the full period
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.duty_a <= DUTY_W'(PWM_PERIOD)) &&
		(out_data.duty_b <= DUTY_W'(PWM_PERIOD)) && (out_data.duty_c <= DUTY_W'(PWM_PERIOD)))
		else $error("duty above period");

endmodule

bind peak_normalized_three_phase_duty pnd_checker u_pnd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
